FILE: rtl/core/tkis_pkg.sv
// tkis_pkg: shared types, widths and helpers for the two-key record insertion sorter
// depends on nothing; imported by every module of the block
package tkis_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int SAL_W  = 20;
  localparam int CAT_W  = 2;
  localparam int TAG_W  = 8;
  localparam int REC_W  = SAL_W + CAT_W + TAG_W;
  localparam int KEY_W  = SAL_W + CAT_W;
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;

  // one stored record
  typedef struct packed {
    logic [SAL_W-1:0] salary;
    logic [CAT_W-1:0] category;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // sort key: salary first, then category
  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {r.salary, r.category};
  endfunction

endpackage

FILE: rtl/core/tkis_store.sv
// tkis_store: single-port-write, single-port-read record memory with a registered read port
// depends on tkis_pkg for the record type
module tkis_store #(
  parameter int DEPTH = tkis_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output tkis_pkg::rec_t rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  tkis_pkg::rec_t wr_data
);
  import tkis_pkg::*;

  rec_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/tkis_ctrl.sv
// tkis_ctrl: insertion sequencer and output unloader around the record memory
// depends on tkis_pkg; drives the ports of tkis_store
module tkis_ctrl #(
  parameter int CAPACITY = tkis_pkg::CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic           clk,
  input  logic           rst,
  // input transactions
  input  logic           in_valid,
  output logic           in_ready,
  input  tkis_pkg::rec_t in_rec,
  input  logic           in_last,
  // output transactions
  output logic           out_valid,
  input  logic           out_ready,
  output tkis_pkg::rec_t out_rec,
  output logic           out_last,
  output logic           out_ovf,
  // memory port
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  tkis_pkg::rec_t rd_data,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output tkis_pkg::rec_t wr_data
);
  import tkis_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SHIFT, PLACE, OUT_RD, OUT_LD
  } state_t;

  state_t        state;
  rec_t          rec;
  logic          last;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] idx;
  logic          dropped;

  logic          in_acc;
  logic          full;
  logic          greater;
  logic          slot_free;
  logic          is_end;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] pos_m2;

  assign in_ready  = (state == IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count >= CW'(CAPACITY));
  assign greater   = (rec_key(rd_data) > rec_key(rec));
  assign slot_free = !out_valid || out_ready;
  assign cnt_m1    = count - CW'(1);
  assign pos_m1    = pos - CW'(1);
  assign pos_m2    = pos - CW'(2);
  assign is_end    = (idx == cnt_m1);

  // memory accesses for each step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rec;
    unique case (state)
      IDLE: begin
        if (in_acc && !full) begin
          if (count == '0) begin
            wr_en   = 1'b1;
            wr_data = in_rec;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m1[AW-1:0];
          end
        end
      end
      SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        if (greater) begin
          wr_data = rd_data;
          if (pos > CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos_m2[AW-1:0];
          end
        end
      end
      PLACE: begin
        wr_en = 1'b1;
      end
      OUT_RD: begin
        if (slot_free) begin
          rd_en   = 1'b1;
          rd_addr = idx[AW-1:0];
        end
      end
      OUT_LD: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      pos       <= '0;
      idx       <= '0;
      dropped   <= 1'b0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            rec  <= in_rec;
            last <= in_last;
            if (full) begin
              dropped <= 1'b1;
              state   <= in_last ? OUT_RD : IDLE;
            end else if (count == '0) begin
              count <= CW'(1);
              state <= in_last ? OUT_RD : IDLE;
            end else begin
              pos   <= count;
              state <= SHIFT;
            end
          end
        end
        SHIFT: begin
          if (greater) begin
            pos   <= pos_m1;
            state <= (pos == CW'(1)) ? PLACE : SHIFT;
          end else begin
            count <= count + CW'(1);
            state <= last ? OUT_RD : IDLE;
          end
        end
        PLACE: begin
          count <= count + CW'(1);
          state <= last ? OUT_RD : IDLE;
        end
        OUT_RD: begin
          if (slot_free) begin
            state <= OUT_LD;
          end
        end
        OUT_LD: begin
          out_rec   <= rd_data;
          out_last  <= is_end;
          out_ovf   <= dropped;
          out_valid <= 1'b1;
          if (is_end) begin
            count   <= '0;
            dropped <= 1'b0;
            idx     <= '0;
            state   <= IDLE;
          end else begin
            idx   <= idx + CW'(1);
            state <= OUT_RD;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/two_key_record_insertion_sorter_top.sv
// two_key_record_insertion_sorter_top: top level of the two-key record insertion sorter
// depends on tkis_pkg, tkis_store and tkis_ctrl
//
// Usage:
//   The slave channel (s_*) takes one record per transaction: salary, category
//   and tag in s_tdata, and s_tlast marking the final record of a set. Records
//   are kept in ascending (salary, category) order in a memory; equal keys keep
//   their arrival order. Up to CAPACITY records are held, further ones are
//   dropped and remembered.
//   Inserting a record into an empty store writes it directly; otherwise the
//   record is compared from the end of the store downwards, and each step shifts
//   one entry with a greater key up through the single read and write port.
//   After the record carrying s_tlast, the master channel (m_*) delivers every
//   stored record in order, each by a memory read followed by an output
//   register load; m_tlast marks the final one and m_tuser flags a set that
//   lost records. The store is then empty and s_tready rises again while the
//   final result may still wait in the output register.
//   If the receiver stalls, the output register holds its transaction and the
//   unloader waits. Reset empties the store and clears the drop flag at once;
//   memory contents are not cleared.
module two_key_record_insertion_sorter_top #(
  parameter int CAPACITY = tkis_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tkis_pkg::DATA_W-1:0] s_tdata,  // salary, category, record_tag, zero pad
  input  logic                        s_tlast,  // last_record
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tkis_pkg::DATA_W-1:0] m_tdata,  // out_salary, out_category, out_tag, zero pad
  output logic                        m_tlast,  // end_of_set
  output logic                        m_tuser   // overflowed
);
  import tkis_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  rec_t          in_rec;
  rec_t          out_rec;
  rec_t          rd_data;
  rec_t          wr_data;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // unpack the incoming record, first field in the lowest bits
  assign in_rec.salary   = s_tdata[SAL_W-1:0];
  assign in_rec.category = s_tdata[SAL_W+CAT_W-1:SAL_W];
  assign in_rec.tag      = s_tdata[REC_W-1:SAL_W+CAT_W];

  // pack the outgoing record the same way
  assign m_tdata = DATA_W'({out_rec.tag, out_rec.category, out_rec.salary});

  tkis_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_rec   (in_rec),
    .in_last  (s_tlast),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_rec  (out_rec),
    .out_last (m_tlast),
    .out_ovf  (m_tuser),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  tkis_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

FILE: rtl/core/tkis_checker.sv
// tkis_checker: port-level assertions for the two-key record insertion sorter
// depends on tkis_pkg; bound to two_key_record_insertion_sorter_top
module tkis_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [tkis_pkg::DATA_W-1:0] m_tdata,
  input logic                        m_tlast,
  input logic                        m_tuser
);
  import tkis_pkg::*;

  // a stalled output transaction keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  // nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // a closing record always starts the unload, so input stops
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after a closing record");

  // no input is taken while a set is still being unloaded
  a_unload_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input taken in the middle of a sorted set");

endmodule

bind two_key_record_insertion_sorter_top tkis_checker u_tkis_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);
